@@ hdl/sfdc_pkg.sv @@
package sfdc_pkg;

   localparam int unsigned MAX_FRAME = 2048;
   localparam int unsigned CNT_W     = 13;
   localparam int unsigned IDX_W     = 12;
   localparam int unsigned OQ_DEPTH  = 4;
   localparam int unsigned OQ_PTR_W  = 2;
   localparam int unsigned OQ_CNT_W  = 3;

   localparam logic [7:0] CH_END      = 8'o300;
   localparam logic [7:0] CH_ESC      = 8'o333;
   localparam logic [7:0] CH_ESC_END  = 8'o334;
   localparam logic [7:0] CH_ESC_ESC  = 8'o335;
   localparam logic [7:0] CH_ESC_XON  = 8'o336;
   localparam logic [7:0] CH_ESC_XOFF = 8'o337;
   localparam logic [7:0] CH_XON      = 8'd17;
   localparam logic [7:0] CH_XOFF     = 8'd19;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_QUERY    = 8'h3F;
   localparam logic [7:0] CH_P        = 8'h50;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [3:0] NIB_LOWER   = 4'h6;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_DROP = 2'd2;

   localparam logic [2:0] CLASS_PACKET = 3'd0;
   localparam logic [2:0] CLASS_TEXT   = 3'd1;
   localparam logic [2:0] CLASS_DEBUG  = 3'd2;
   localparam logic [2:0] CLASS_PREFIX = 3'd3;
   localparam logic [2:0] CLASS_QUERY  = 3'd4;

   typedef struct packed {
      logic [1:0]       out_kind;
      logic [7:0]       data_byte;
      logic [IDX_W-1:0] byte_index;
      logic [2:0]       frame_class;
      logic [CNT_W-1:0] frame_length;
      logic             last;
   } result_type;

   typedef struct packed {
      logic [1:0] num;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

@@ hdl/sfdc_core.sv @@
module sfdc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        rx_byte,
   output sfdc_pkg::push_type push
);
   import sfdc_pkg::*;

   logic             esc_ff, esc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       second_ff, second_in;
   logic             text_ok_ff, text_ok_in;

   logic [7:0]       dec;
   logic [CNT_W-1:0] count_inc;
   logic [2:0]       cls;
   logic             flow;
   logic             printable;
   result_type       none;

   always_comb begin
      dec = rx_byte;
      if (esc_ff) begin
         case (rx_byte)
            CH_ESC_END:  dec = CH_END;
            CH_ESC_ESC:  dec = CH_ESC;
            CH_ESC_XON:  dec = CH_XON;
            CH_ESC_XOFF: dec = CH_XOFF;
            default:     dec = rx_byte;
         endcase
      end
   end

   assign printable = (dec == CH_NUL) || (dec == CH_CR) || (dec == CH_LF) ||
                      (dec == CH_TAB) || ((dec >= CH_SPACE) && (dec <= CH_TILDE));

   assign flow = (count_ff >= CNT_W'(2)) && (first_ff[7:4] == NIB_LOWER) &&
                 ((second_ff == CH_CR) || (second_ff == CH_LF) ||
                  (second_ff == CH_TAB));

   always_comb begin
      if (first_ff == CH_QUERY) begin
         cls = ((count_ff >= CNT_W'(2)) && (second_ff == CH_P)) ? CLASS_PREFIX
                                                                  : CLASS_QUERY;
      end else if (first_ff == CH_CR) begin
         cls = CLASS_DEBUG;
      end else if (text_ok_ff && !flow) begin
         cls = CLASS_TEXT;
      end else begin
         cls = CLASS_PACKET;
      end
   end

   assign count_inc = count_ff + CNT_W'(1);
   assign none      = '0;

   always_comb begin
      esc_in     = esc_ff;
      count_in   = count_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      text_ok_in = text_ok_ff;
      push       = '{num: 2'd0, r0: none, r1: none};
      if (take) begin
         if (!esc_ff && (rx_byte == CH_END)) begin
            if (count_ff != '0) begin
               push.num             = 2'd1;
               push.r0.out_kind     = KIND_END;
               push.r0.frame_class  = cls;
               push.r0.frame_length = count_ff;
               push.r0.last         = 1'b1;
               count_in             = '0;
               first_in             = '0;
               second_in            = '0;
               text_ok_in           = 1'b1;
            end
         end else if (!esc_ff && (rx_byte == CH_ESC)) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            if (count_ff == '0) begin
               first_in = dec;
            end else begin
               if (count_ff == CNT_W'(1)) begin
                  second_in = dec;
               end
               if (!printable) begin
                  text_ok_in = 1'b0;
               end
            end
            count_in           = count_inc;
            push.num           = 2'd1;
            push.r0.out_kind   = KIND_DATA;
            push.r0.data_byte  = dec;
            push.r0.byte_index = count_ff[IDX_W-1:0];
            push.r0.last       = 1'b1;
            if (count_inc >= CNT_W'(MAX_FRAME)) begin
               push.num             = 2'd2;
               push.r0.last         = 1'b0;
               push.r1.out_kind     = KIND_DROP;
               push.r1.frame_length = count_inc;
               push.r1.last         = 1'b1;
               count_in             = '0;
               first_in             = '0;
               second_in            = '0;
               text_ok_in           = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff     <= 1'b0;
         count_ff   <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
         text_ok_ff <= 1'b1;
      end else begin
         esc_ff     <= esc_in;
         count_ff   <= count_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         text_ok_ff <= text_ok_in;
      end
   end

endmodule

@@ hdl/sfdc_outq.sv @@
module sfdc_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  sfdc_pkg::push_type   push,
   input  logic                 pop,
   output logic                 not_empty,
   output logic                 full,
   output sfdc_pkg::result_type head
);
   import sfdc_pkg::*;

   result_type          entry_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] wr_ff, wr_in;
   logic [OQ_PTR_W-1:0] rd_ff, rd_in;
   logic [OQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                do_pop;

   assign not_empty = (cnt_ff != '0);
   // room for two words is needed before another byte is taken
   assign full      = (cnt_ff > OQ_CNT_W'(OQ_DEPTH - 2));
   assign head      = entry_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   assign wr_in  = wr_ff + OQ_PTR_W'(push.num);
   assign rd_in  = rd_ff + OQ_PTR_W'(do_pop);
   assign cnt_in = cnt_ff + OQ_CNT_W'(push.num) - OQ_CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ff] <= push.r0;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_ff + OQ_PTR_W'(1)] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/slip_frame_decoder_classifier_top.sv @@
// SLIP receive decoder with frame classification.
// req channel: one raw serial byte per word (req_rx_byte), taken when
//   req_valid is high and req_stall is low.
// rsp channel: one result per word: a decoded data byte with its position,
//   a frame end with length and class, or an oversize-drop flag with length.
//   rsp_last marks the final word caused by one input byte.
// A result word is registered in the output queue when its byte is taken.
// Throughput: one byte per cycle while req_stall is low. END on an empty
//   frame and ESC make no word; a byte that fills the frame to its maximum
//   makes two words, which leave in turn. A four-word output queue sets
//   the slack: req_stall rises when fewer than two free entries remain.
// Stall: while rsp_stall is high the head word holds; the queue keeps taking
//   bytes until it nears full, then req_stall is raised.
// Reset: synchronous; clears the escape flag, the frame in progress and the
//   output queue. No word is pending after reset.
module slip_frame_decoder_classifier_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_out_kind,
   output logic [7:0]               rsp_data_byte,
   output logic [sfdc_pkg::IDX_W-1:0] rsp_byte_index,
   output logic [2:0]               rsp_frame_class,
   output logic [sfdc_pkg::CNT_W-1:0] rsp_frame_length,
   output logic                     rsp_last
);
   import sfdc_pkg::*;

   push_type   push;
   result_type head;
   logic       full;
   logic       take;

   assign req_stall = full;
   assign take      = req_valid && !full;

   sfdc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .push    (push)
   );

   sfdc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .not_empty (rsp_valid),
      .full      (full),
      .head      (head)
   );

   assign rsp_out_kind     = head.out_kind;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_byte_index   = head.byte_index;
   assign rsp_frame_class  = head.frame_class;
   assign rsp_frame_length = head.frame_length;
   assign rsp_last         = head.last;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
   import sfdc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 80;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_out_kind;
   logic [7:0]           rsp_data_byte;
   logic [IDX_W-1:0]     rsp_byte_index;
   logic [2:0]           rsp_frame_class;
   logic [CNT_W-1:0]     rsp_frame_length;
   logic                 rsp_last;

   // decoder state as seen by the predictor
   logic                 esc_pending = 1'b0;
   logic [CNT_W-1:0]     frame_len = '0;
   logic [7:0]           first_b = 8'h00;
   logic [7:0]           second_b = 8'h00;
   logic                 text_ok = 1'b1;

   result_type           decoded_words[$];
   int                   send_gap_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   hold_left = 0;
   int                   bytes_sent = 0;
   int                   mismatches = 0;
   int                   cycles = 0;

   slip_frame_decoder_classifier_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_class  (rsp_frame_class),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic clear_frame();
      frame_len = '0;
      first_b = 8'h00;
      second_b = 8'h00;
      text_ok = 1'b1;
   endtask

   task automatic decode_slip_byte(input logic [7:0] raw);
      logic [7:0] c;
      logic [2:0] cls;
      result_type w;
      c = raw;
      w = '0;
      if (!esc_pending) begin
         if (raw == CH_END) begin
            if (frame_len != 0) begin
               if (first_b == CH_QUERY) begin
                  cls = (frame_len >= 2 && second_b == CH_P) ? CLASS_PREFIX : CLASS_QUERY;
               end else if (first_b == CH_CR) begin
                  cls = CLASS_DEBUG;
               end else if (text_ok && !(frame_len >= 2 && first_b[7:4] == NIB_LOWER &&
                            (second_b == CH_CR || second_b == CH_LF || second_b == CH_TAB)))
               begin
                  cls = CLASS_TEXT;
               end else begin
                  cls = CLASS_PACKET;
               end
               w.out_kind = KIND_END;
               w.frame_class = cls;
               w.frame_length = frame_len;
               w.last = 1'b1;
               decoded_words.push_back(w);
               clear_frame();
            end
            return;
         end
         if (raw == CH_ESC) begin
            esc_pending = 1'b1;
            return;
         end
      end else begin
         esc_pending = 1'b0;
         case (raw)
            CH_ESC_END:  c = CH_END;
            CH_ESC_ESC:  c = CH_ESC;
            CH_ESC_XON:  c = CH_XON;
            CH_ESC_XOFF: c = CH_XOFF;
            default:     c = raw;
         endcase
      end
      if (frame_len == 0) begin
         first_b = c;
      end else begin
         if (frame_len == 1) second_b = c;
         if (!(c == CH_NUL || c == CH_CR || c == CH_LF || c == CH_TAB ||
               (c >= CH_SPACE && c <= CH_TILDE))) text_ok = 1'b0;
      end
      w.out_kind = KIND_DATA;
      w.data_byte = c;
      w.byte_index = frame_len[IDX_W-1:0];
      frame_len = frame_len + 1'b1;
      if (frame_len >= MAX_FRAME) begin
         decoded_words.push_back(w);
         w = '0;
         w.out_kind = KIND_DROP;
         w.frame_length = frame_len;
         w.last = 1'b1;
         decoded_words.push_back(w);
         clear_frame();
      end else begin
         w.last = 1'b1;
         decoded_words.push_back(w);
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_words.size() == 0) begin
            $error("unexpected word: kind %0d data %0d", rsp_out_kind, rsp_data_byte);
            mismatches++;
         end else begin
            want = decoded_words.pop_front();
            compare_field("out_kind", want.out_kind, rsp_out_kind);
            compare_field("data_byte", want.data_byte, rsp_data_byte);
            compare_field("byte_index", want.byte_index, rsp_byte_index);
            compare_field("frame_class", want.frame_class, rsp_frame_class);
            compare_field("frame_length", want.frame_length, rsp_frame_length);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      decode_slip_byte(b);
      bytes_sent++;
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_valid = 1'b0;
      while (decoded_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] text_char();
      case ($urandom_range(9))
         0:       return CH_NUL;
         1:       return CH_CR;
         2:       return CH_LF;
         3:       return CH_TAB;
         default: return 8'($urandom_range(CH_TILDE, CH_SPACE));
      endcase
   endfunction

   // encode one decoded byte onto the line, escaping where needed and sometimes where not
   task automatic send_decoded(input logic [7:0] b);
      if (b == CH_END) begin
         send_byte(CH_ESC);
         send_byte(CH_ESC_END);
      end else if (b == CH_ESC) begin
         send_byte(CH_ESC);
         send_byte(CH_ESC_ESC);
      end else if (b == CH_XON && $urandom_range(1)) begin
         send_byte(CH_ESC);
         send_byte(CH_ESC_XON);
      end else if (b == CH_XOFF && $urandom_range(1)) begin
         send_byte(CH_ESC);
         send_byte(CH_ESC_XOFF);
      end else if ($urandom_range(19) == 0 && (b < CH_ESC_END || b > CH_ESC_XOFF)) begin
         send_byte(CH_ESC);
         send_byte(b);
      end else begin
         send_byte(b);
      end
   endtask

   task automatic send_random_frame();
      int len;
      int i;
      logic [7:0] b;
      len = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(10, 1);
      for (i = 0; i < len; i++) begin
         if (i == 0) begin
            case ($urandom_range(5))
               0:       b = CH_QUERY;
               1:       b = CH_CR;
               2:       b = {NIB_LOWER, 4'($urandom_range(15))};
               3:       b = text_char();
               default: b = 8'($urandom_range(255));
            endcase
         end else if (i == 1) begin
            case ($urandom_range(5))
               0:       b = CH_P;
               1:       b = CH_CR;
               2:       b = CH_LF;
               3:       b = CH_TAB;
               4:       b = text_char();
               default: b = 8'($urandom_range(255));
            endcase
         end else begin
            b = ($urandom_range(7) != 0) ? text_char() : 8'($urandom_range(255));
         end
         send_decoded(b);
      end
      send_byte(CH_END);
   endtask

   task automatic test_frame_classes();
      send_byte(CH_END);
      send_byte(CH_QUERY);
      send_byte(CH_P);
      send_byte(CH_END);
      send_byte(CH_QUERY);
      send_byte(CH_END);
      send_byte(CH_CR);
      send_byte(CH_END);
      send_byte(8'h61);
      send_byte(CH_LF);
      send_byte(CH_END);
      send_byte(CH_SPACE);
      send_byte(CH_TILDE);
      send_byte(CH_END);
   endtask

   task automatic test_escapes();
      send_byte(CH_NUL);
      send_byte(CH_ESC);
      send_byte(CH_ESC_END);
      send_byte(CH_ESC);
      send_byte(CH_ESC_ESC);
      send_byte(CH_ESC);
      send_byte(CH_ESC_XON);
      send_byte(CH_ESC);
      send_byte(CH_ESC_XOFF);
      // raw END and ESC as code bytes pass through
      send_byte(CH_ESC);
      send_byte(CH_END);
      send_byte(CH_ESC);
      send_byte(CH_ESC);
      send_byte(8'hFF);
      send_byte(CH_END);
   endtask

   task automatic test_fill_and_drain();
      int i;
      int saved_gap;
      drain_words();
      saved_gap = send_gap_pct;
      send_gap_pct = 0;
      hold_left = HOLD_CYCLES;
      for (i = 0; i < 24; i++) send_byte(text_char());
      send_byte(CH_END);
      drain_words();
      send_gap_pct = saved_gap;
   endtask

   task automatic test_random_frames(input int n_bytes);
      int stop_at;
      int pick;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            send_random_frame();
         end else if (pick < 93) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end else begin
            case ($urandom_range(2))
               0: send_byte(CH_END);
               1: begin
                  send_byte(CH_ESC);
                  send_byte(CH_END);
               end
               default: begin
                  send_byte(CH_ESC);
                  send_byte(CH_ESC);
               end
            endcase
         end
      end
   endtask

   task automatic test_oversize_frame();
      int i;
      for (i = 0; i < MAX_FRAME - 1; i++) send_decoded(text_char());
      send_byte(CH_END);
      for (i = 0; i < MAX_FRAME - 1; i++) send_decoded(8'($urandom_range(255)));
      send_decoded(CH_END);
      send_byte(CH_QUERY);
      send_byte(CH_P);
      send_byte(CH_END);
   endtask

   initial begin
      send_gap_pct = 28;
      rsp_stall_pct = 46;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_frame_classes();
      test_escapes();
      test_fill_and_drain();
      test_random_frames(170);

      send_gap_pct = 46;
      rsp_stall_pct = 28;
      test_random_frames(170);
      test_oversize_frame();

      send_gap_pct = 0;
      rsp_stall_pct = 0;
      test_random_frames(170);

      drain_words();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && decoded_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
